// ===== rtl/awr_pkg.sv =====
// ----------------------------------------------------------------------------
// awr_pkg
// shared types, constants and gain table functions for the ramped abs shaper
// ----------------------------------------------------------------------------
package awr_pkg;

   localparam int AWR_MAX_BLOCK       = 4096;
   localparam int AWR_GAIN_TABLE_SIZE = 1024;
   localparam int AWR_SAMPLE_BITS     = 24;

   localparam int NUM_RAMPS  = 5;
   localparam int PARAM_BITS = 17;
   localparam int MOD_BITS   = 18;
   localparam int NF_BITS    = 13;
   localparam int RAMP_BITS  = 48;
   localparam int WORD_BITS  = 64;
   localparam int CSR_BITS   = 3;

   // register and ramp indexes share one order
   localparam logic [CSR_BITS-1:0] CSR_DRYWET = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_DRIVE  = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_OFFSET = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_ABS    = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_BLEND  = 3'd4;
   localparam logic [CSR_BITS-1:0] CSR_LAST   = CSR_BLEND;

   localparam logic [PARAM_BITS-1:0] PARAM_RESET [NUM_RAMPS] =
      '{17'd65536, 17'd32768, 17'd32768, 17'd65536, 17'd0};

   localparam logic signed [RAMP_BITS:0] RAMP_LO [NUM_RAMPS] =
      '{49'sd0, 49'sd0, -49'sh3_0000_0000, 49'sd0, 49'sd0};
   localparam logic signed [RAMP_BITS:0] RAMP_HI [NUM_RAMPS] =
      '{49'sh1_0000_0000, 49'sh2710_0000_0000, 49'sh6_0000_0000,
        49'sh1_0000_0000, 49'sh1_0000_0000};

   typedef struct packed {
      logic                         start;
      logic signed [WORD_BITS-1:0]  a;
      logic [RAMP_BITS-1:0]         c;
   } awr_mul_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [WORD_BITS-1:0]  res;
   } awr_mul_rsp_type;

   typedef struct packed {
      logic                         start;
      logic signed [RAMP_BITS-1:0]  dividend;
      logic [NF_BITS-1:0]           divisor;
   } awr_div_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [RAMP_BITS-1:0]  quot;
   } awr_div_rsp_type;

   function automatic logic [63:0] awr_isqrt_f(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = n_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (b > n) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != '0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] awr_udiv_f(input logic [63:0] x, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], x[i]};
         if (r >= d) begin
            r = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] awr_exp10_f(input logic signed [63:0] e);
      logic signed [63:0] ec;
      logic signed [63:0] eo;
      logic [31:0]        f;
      int                 ip;
      logic [63:0]        m;
      logic [63:0]        rt;
      ec = e;
      if (ec < -(64'sd4 <<< 32)) ec = -(64'sd4 <<< 32);
      if (ec > (64'sd4 <<< 32)) ec = 64'sd4 <<< 32;
      eo = ec + (64'sd8 <<< 32);
      ip = int'(eo[63:32]) - 8;
      f  = eo[31:0];
      m  = 64'd1 << 28;
      rt = 64'd10 << 28;
      for (int k = 1; k <= 24; k++) begin
         rt = awr_isqrt_f(rt << 28);
         if (f[32-k]) m = (m * rt) >> 28;
      end
      m = m << 4;
      for (int i = 0; i < 4; i++) begin
         if (ip > 0) begin
            m  = m * 64'd10;
            ip = ip - 1;
         end else if (ip < 0) begin
            m  = m / 64'd10;
            ip = ip + 1;
         end
      end
      return m;
   endfunction

   function automatic logic [63:0] awr_gain_entry_f(input int i, input int g);
      logic signed [63:0] num;
      logic [63:0]        mag;
      logic [63:0]        q;
      num = 64'(8 * i - 4 * (g - 1));
      mag = (num < 0) ? 64'(-num) : 64'(num);
      q   = awr_udiv_f(mag << 32, 64'(g - 1));
      return awr_exp10_f((num < 0) ? -signed'(q) : signed'(q));
   endfunction

endpackage

// ===== rtl/awr_req_if.sv =====
// ----------------------------------------------------------------------------
// awr_req_if
// input item channel: prepare or frame items with valid/ready
// ----------------------------------------------------------------------------
interface awr_req_if import awr_pkg::*; #(
   parameter int SAMPLE_BITS = AWR_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [NF_BITS-1:0]            num_frames;
   logic signed [MOD_BITS-1:0]    drywet_mod;
   logic signed [MOD_BITS-1:0]    drive_mod;
   logic signed [MOD_BITS-1:0]    offset_mod;
   logic signed [MOD_BITS-1:0]    abs_mod;
   logic signed [MOD_BITS-1:0]    blend_mod;
   logic                          mono_in;
   logic signed [SAMPLE_BITS-1:0] sample_left;
   logic signed [SAMPLE_BITS-1:0] sample_right;

   modport source (output valid, func, num_frames, drywet_mod, drive_mod, offset_mod,
                   abs_mod, blend_mod, mono_in, sample_left, sample_right,
                   input ready);
   modport sink (input valid, func, num_frames, drywet_mod, drive_mod, offset_mod,
                 abs_mod, blend_mod, mono_in, sample_left, sample_right,
                 output ready);
endinterface

// ===== rtl/awr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// awr_rsp_if
// result channel: shaped stereo sample pair with valid/ready
// ----------------------------------------------------------------------------
interface awr_rsp_if import awr_pkg::*; #(
   parameter int SAMPLE_BITS = AWR_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_left;
   logic signed [SAMPLE_BITS-1:0] out_right;

   modport source (output valid, out_left, out_right, input ready);
   modport sink (input valid, out_left, out_right, output ready);
endinterface

// ===== rtl/awr_csr_if.sv =====
// ----------------------------------------------------------------------------
// awr_csr_if
// register write channel: index and data with valid/ready
// ----------------------------------------------------------------------------
interface awr_csr_if import awr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_BITS-1:0]   index;
   logic [PARAM_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/awr_mul.sv =====
// ----------------------------------------------------------------------------
// awr_mul
// shared signed-by-unsigned fractional multiplier, 32x24 partial product
// per cycle, result is the magnitude product shifted down 32 bits
// ----------------------------------------------------------------------------
module awr_mul import awr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  awr_mul_req_type mul_req,
   output awr_mul_rsp_type mul_rsp
);
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [63:0]          am_ff, am_in;
   logic [47:0]          c_ff, c_in;
   logic [111:0]         acc_ff, acc_in;
   logic [31:0]          pa;
   logic [23:0]          pc;
   logic [55:0]          prod;
   logic [111:0]         term;
   logic [63:0]          mag;

   always_comb begin
      pa   = cnt_ff[1] ? am_ff[63:32] : am_ff[31:0];
      pc   = cnt_ff[0] ? c_ff[47:24] : c_ff[23:0];
      prod = 56'(pa) * 56'(pc);
      case (cnt_ff)
         2'd0:    term = 112'(prod);
         2'd1:    term = 112'(prod) << 24;
         2'd2:    term = 112'(prod) << 32;
         default: term = 112'(prod) << 56;
      endcase
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      am_in   = am_ff;
      c_in    = c_ff;
      acc_in  = acc_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
         neg_in  = mul_req.a[63];
         am_in   = mul_req.a[63] ? 64'(-mul_req.a) : 64'(mul_req.a);
         c_in    = mul_req.c;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + term;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      mag          = acc_ff[95:32];
      mul_rsp.done = done_ff;
      mul_rsp.res  = neg_ff ? -signed'(mag) : signed'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      am_ff  <= am_in;
      c_ff   <= c_in;
      acc_ff <= acc_in;
   end
endmodule

// ===== rtl/awr_div.sv =====
// ----------------------------------------------------------------------------
// awr_div
// restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module awr_div import awr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  awr_div_req_type div_req,
   output awr_div_rsp_type div_rsp
);
   localparam int CNT_BITS = $clog2(RAMP_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [RAMP_BITS-1:0] dm_ff, dm_in;
   logic [RAMP_BITS-1:0] q_ff, q_in;
   logic [NF_BITS-1:0]   rem_ff, rem_in;
   logic [NF_BITS-1:0]   d_ff, d_in;
   logic [NF_BITS:0]     trial;

   always_comb begin
      trial   = {rem_ff, dm_ff[RAMP_BITS-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      dm_in   = dm_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = div_req.dividend[RAMP_BITS-1];
         dm_in   = div_req.dividend[RAMP_BITS-1] ? RAMP_BITS'(-div_req.dividend)
                                                 : RAMP_BITS'(div_req.dividend);
         q_in    = '0;
         rem_in  = '0;
         d_in    = div_req.divisor;
      end else if (busy_ff) begin
         dm_in = {dm_ff[RAMP_BITS-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            rem_in = NF_BITS'(trial - {1'b0, d_ff});
            q_in   = {q_ff[RAMP_BITS-2:0], 1'b1};
         end else begin
            rem_in = NF_BITS'(trial);
            q_in   = {q_ff[RAMP_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(RAMP_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      div_rsp.done = done_ff;
      div_rsp.quot = neg_ff ? -signed'(q_ff) : signed'(q_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      dm_ff  <= dm_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end
endmodule

// ===== rtl/abs_waveshaper_ramped.sv =====
// ----------------------------------------------------------------------------
// abs_waveshaper_ramped
// abs waveshaper with per-frame linear parameter ramps
// ----------------------------------------------------------------------------
// req_if takes one item per transfer. func 0 is a prepare item: five targets
// are formed from the csr registers and the modulation fields and the ramps
// are set up over num_frames frames; it gives no result. func 1 is a frame
// item: one result pair goes out on rsp_if and the ramps advance.
// csr_if takes a write on every cycle; a prepare uses the register values
// held at its transfer.
// A frame makes five passes per channel through the shared multiplier (gain,
// abs, product, blend and mix), over one channel in mono and two in stereo;
// the result pair then goes to S_OUT, where the ramps advance.
// A prepare does the gain table lookup through the same multiplier (position,
// table reads and, unless the index is at the top or the entries do not rise,
// an interpolation pass) plus a setup step, and then one divider run per ramp
// when num_frames is not zero.
// req_if.ready is high only while the sequencer is idle.
// Results sit in an output register; if the receiver stalls the next frame
// completes and holds until that register is free.
// Reset loads the knob registers with their defaults and clears all ramps,
// so frames before any prepare pass the dry input.
// ----------------------------------------------------------------------------
module abs_waveshaper_ramped import awr_pkg::*; #(
   parameter int MAX_BLOCK       = AWR_MAX_BLOCK,
   parameter int GAIN_TABLE_SIZE = AWR_GAIN_TABLE_SIZE,
   parameter int SAMPLE_BITS     = AWR_SAMPLE_BITS
) (
   input logic        clock,
   input logic        reset,
   awr_req_if.sink    req_if,
   awr_rsp_if.source  rsp_if,
   awr_csr_if.sink    csr_if
);
   localparam int GW        = $clog2(GAIN_TABLE_SIZE);
   localparam int OFS_SHIFT = 32 - SAMPLE_BITS;
   localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SMIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_MUL  = 8'b0000_0010,
      S_GRD0 = 8'b0000_0100,
      S_GRD1 = 8'b0000_1000,
      S_GCHK = 8'b0001_0000,
      S_SET  = 8'b0010_0000,
      S_DIV  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      OP_POS, OP_INTERP, OP_GAIN, OP_ABS, OP_PROD, OP_BLEND, OP_MIX
   } op_type;

   function automatic logic signed [RAMP_BITS-1:0] unit_tgt_f(
      input logic [PARAM_BITS-1:0] p, input logic signed [MOD_BITS-1:0] m);
      logic signed [19:0] s;
      s = signed'(20'(p)) + 20'(m);
      if (s < 20'sd0) s = 20'sd0;
      if (s > 20'sd65536) s = 20'sd65536;
      return RAMP_BITS'(s) <<< 16;
   endfunction

   function automatic logic signed [20:0] knob_f(
      input logic [PARAM_BITS-1:0] p, input logic signed [MOD_BITS-1:0] m);
      return ((signed'(21'(p)) - 21'sd32768) <<< 1) + 21'(m);
   endfunction

   logic [RAMP_BITS-1:0] gain_rom [GAIN_TABLE_SIZE];
   for (genvar gi = 0; gi < GAIN_TABLE_SIZE; gi++) begin : g_gain
      localparam logic [RAMP_BITS-1:0] ENTRY =
         RAMP_BITS'(awr_gain_entry_f(gi, GAIN_TABLE_SIZE));
      assign gain_rom[gi] = ENTRY;
   end

   state_type                      state_ff, state_in;
   op_type                         op_ff, op_in;
   logic                           issued_ff, issued_in;
   logic [CSR_BITS-1:0]            k_ff, k_in;
   logic [NF_BITS-1:0]             n_ff, n_in;
   logic [PARAM_BITS-1:0]          p_ff [NUM_RAMPS];
   logic [PARAM_BITS-1:0]          p_in [NUM_RAMPS];
   logic signed [RAMP_BITS-1:0]    tgt_ff [NUM_RAMPS];
   logic signed [RAMP_BITS-1:0]    tgt_in [NUM_RAMPS];
   logic signed [RAMP_BITS-1:0]    now_ff [NUM_RAMPS];
   logic signed [RAMP_BITS-1:0]    now_in [NUM_RAMPS];
   logic signed [RAMP_BITS-1:0]    step_ff [NUM_RAMPS];
   logic signed [RAMP_BITS-1:0]    step_in [NUM_RAMPS];
   logic [GW-1:0]                  idx_ff, idx_in;
   logic                           top_ff, top_in;
   logic [15:0]                    fr_ff, fr_in;
   logic [RAMP_BITS-1:0]           lo_ff, lo_in;
   logic [RAMP_BITS-1:0]           hi_ff, hi_in;
   logic signed [63:0]             xq_ff, xq_in;
   logic signed [63:0]             o_ff, o_in;
   logic signed [63:0]             t_ff, t_in;
   logic signed [SAMPLE_BITS-1:0]  samp_r_ff, samp_r_in;
   logic                           mono_ff, mono_in;
   logic                           ch_ff, ch_in;
   logic signed [SAMPLE_BITS-1:0]  res_l_ff, res_l_in;
   logic signed [SAMPLE_BITS-1:0]  res_r_ff, res_r_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]  out_l_ff, out_l_in;
   logic signed [SAMPLE_BITS-1:0]  out_r_ff, out_r_in;

   awr_mul_req_type mul_req;
   awr_mul_rsp_type mul_rsp;
   awr_div_req_type div_req;
   awr_div_rsp_type div_rsp;

   logic                 req_fire;
   logic                 csr_fire;
   logic signed [20:0]   xd;
   logic signed [20:0]   xc;
   logic signed [63:0]   ofs;
   logic [63:0]          ax;
   logic signed [63:0]   mix_d;
   logic signed [63:0]   mix_r;
   logic signed [63:0]   sat;
   logic [16:0]          idx_raw;
   logic signed [RAMP_BITS:0] sum;

   awr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   awr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_if.ready     = (state_ff == S_IDLE);
   assign csr_if.ready     = 1'b1;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_left  = out_l_ff;
   assign rsp_if.out_right = out_r_ff;

   always_comb begin
      req_fire = req_if.valid && (state_ff == S_IDLE);
      csr_fire = csr_if.valid;
      xd  = knob_f(p_ff[CSR_DRIVE], req_if.drive_mod);
      xc  = xd;
      if (xc < -21'sd131072) xc = -21'sd131072;
      if (xc > 21'sd131072) xc = 21'sd131072;
      ofs = 64'(now_ff[CSR_OFFSET]) >>> OFS_SHIFT;
      ax  = xq_ff[63] ? 64'(-xq_ff) : 64'(xq_ff);
      mix_d = xq_ff + mul_rsp.res;
      mix_r = (mix_d + 64'sd1) >>> 1;
      sat   = mix_r;
      if (mix_r > SMAX) sat = SMAX;
      if (mix_r < SMIN) sat = SMIN;
      idx_raw = 17'(mul_rsp.res >>> 18);
      sum = '0;

      state_in     = state_ff;
      op_in        = op_ff;
      issued_in    = issued_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      tgt_in       = tgt_ff;
      now_in       = now_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      top_in       = top_ff;
      fr_in        = fr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      xq_in        = xq_ff;
      o_in         = o_ff;
      t_in         = t_ff;
      samp_r_in    = samp_r_ff;
      mono_in      = mono_ff;
      ch_in        = ch_ff;
      res_l_in     = res_l_ff;
      res_r_in     = res_r_ff;
      rsp_valid_in = rsp_valid_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;

      mul_req.start    = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = RAMP_BITS'(tgt_ff[k_ff] - now_ff[k_ff]);
      div_req.divisor  = n_ff;

      case (op_ff)
         OP_POS: begin
            mul_req.a = o_ff;
            mul_req.c = RAMP_BITS'(GAIN_TABLE_SIZE - 1) << 32;
         end
         OP_INTERP: begin
            mul_req.a = signed'(64'(hi_ff - lo_ff));
            mul_req.c = RAMP_BITS'({fr_ff, 16'h0000});
         end
         OP_GAIN: begin
            mul_req.a = xq_ff + ofs;
            mul_req.c = unsigned'(now_ff[CSR_DRIVE]);
         end
         OP_ABS: begin
            mul_req.a = o_ff[63] ? -(o_ff <<< 1) : 64'sd0;
            mul_req.c = unsigned'(now_ff[CSR_ABS]);
         end
         OP_PROD: begin
            mul_req.a = o_ff;
            mul_req.c = RAMP_BITS'(ax << OFS_SHIFT);
         end
         OP_BLEND: begin
            mul_req.a = t_ff - o_ff;
            mul_req.c = unsigned'(now_ff[CSR_BLEND]);
         end
         default: begin
            mul_req.a = o_ff - xq_ff;
            mul_req.c = unsigned'(now_ff[CSR_DRYWET]);
         end
      endcase

      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!req_if.func) begin
                  n_in = ({4'b0, req_if.num_frames} > 17'(MAX_BLOCK)) ?
                         NF_BITS'(MAX_BLOCK) : req_if.num_frames;
                  tgt_in[CSR_DRYWET] = unit_tgt_f(p_ff[CSR_DRYWET], req_if.drywet_mod);
                  tgt_in[CSR_ABS]    = unit_tgt_f(p_ff[CSR_ABS], req_if.abs_mod);
                  tgt_in[CSR_BLEND]  = unit_tgt_f(p_ff[CSR_BLEND], req_if.blend_mod);
                  tgt_in[CSR_OFFSET] =
                     RAMP_BITS'(knob_f(p_ff[CSR_OFFSET], req_if.offset_mod)) <<< 16;
                  o_in     = 64'(xc) + 64'sd131072;
                  op_in    = OP_POS;
                  state_in = S_MUL;
               end else begin
                  xq_in     = 64'(req_if.sample_left) <<< 1;
                  samp_r_in = req_if.sample_right;
                  mono_in   = req_if.mono_in;
                  ch_in     = 1'b0;
                  op_in     = OP_GAIN;
                  state_in  = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               case (op_ff)
                  OP_POS: begin
                     fr_in = mul_rsp.res[17:2];
                     if (idx_raw >= 17'(GAIN_TABLE_SIZE - 1)) begin
                        idx_in = GW'(GAIN_TABLE_SIZE - 1);
                        top_in = 1'b1;
                     end else begin
                        idx_in = GW'(idx_raw);
                        top_in = 1'b0;
                     end
                     state_in = S_GRD0;
                  end
                  OP_INTERP: begin
                     tgt_in[CSR_DRIVE] = signed'(lo_ff + RAMP_BITS'(mul_rsp.res));
                     state_in = S_SET;
                  end
                  OP_GAIN: begin
                     o_in  = mul_rsp.res;
                     op_in = OP_ABS;
                  end
                  OP_ABS: begin
                     o_in  = o_ff + mul_rsp.res;
                     op_in = OP_PROD;
                  end
                  OP_PROD: begin
                     t_in  = mul_rsp.res;
                     op_in = OP_BLEND;
                  end
                  OP_BLEND: begin
                     o_in  = o_ff + mul_rsp.res;
                     op_in = OP_MIX;
                  end
                  default: begin
                     if (!ch_ff) begin
                        res_l_in = SAMPLE_BITS'(sat);
                        if (mono_ff) begin
                           res_r_in = SAMPLE_BITS'(sat);
                           state_in = S_OUT;
                        end else begin
                           ch_in = 1'b1;
                           xq_in = 64'(samp_r_ff) <<< 1;
                           op_in = OP_GAIN;
                        end
                     end else begin
                        res_r_in = SAMPLE_BITS'(sat);
                        state_in = S_OUT;
                     end
                  end
               endcase
            end
         end
         S_GRD0: begin
            lo_in = gain_rom[idx_ff];
            if (top_ff) begin
               tgt_in[CSR_DRIVE] = signed'(gain_rom[idx_ff]);
               state_in = S_SET;
            end else begin
               state_in = S_GRD1;
            end
         end
         S_GRD1: begin
            hi_in    = gain_rom[GW'(idx_ff + 1'b1)];
            state_in = S_GCHK;
         end
         S_GCHK: begin
            if (hi_ff <= lo_ff) begin
               tgt_in[CSR_DRIVE] = signed'(lo_ff);
               state_in = S_SET;
            end else begin
               op_in    = OP_INTERP;
               state_in = S_MUL;
            end
         end
         S_SET: begin
            if (n_ff == '0) begin
               for (int k = 0; k < NUM_RAMPS; k++) begin
                  now_in[k]  = tgt_ff[k];
                  step_in[k] = '0;
               end
               state_in = S_IDLE;
            end else begin
               k_in     = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!issued_ff) begin
               div_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (div_rsp.done) begin
               issued_in     = 1'b0;
               step_in[k_ff] = div_rsp.quot;
               if (k_ff == CSR_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               out_l_in     = res_l_ff;
               out_r_in     = res_r_ff;
               rsp_valid_in = 1'b1;
               for (int k = 0; k < NUM_RAMPS; k++) begin
                  sum = (RAMP_BITS+1)'(now_ff[k]) + (RAMP_BITS+1)'(step_ff[k]);
                  if (sum < RAMP_LO[k]) sum = RAMP_LO[k];
                  if (sum > RAMP_HI[k]) sum = RAMP_HI[k];
                  now_in[k] = RAMP_BITS'(sum);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_fire && (csr_if.index <= CSR_LAST)) p_in[csr_if.index] = csr_if.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_POS;
         issued_ff    <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         p_ff         <= PARAM_RESET;
         now_ff       <= '{default: '0};
         step_ff      <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         issued_ff    <= issued_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         p_ff         <= p_in;
         now_ff       <= now_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      tgt_ff    <= tgt_in;
      idx_ff    <= idx_in;
      top_ff    <= top_in;
      fr_ff     <= fr_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      xq_ff     <= xq_in;
      o_ff      <= o_in;
      t_ff      <= t_in;
      samp_r_ff <= samp_r_in;
      mono_ff   <= mono_in;
      ch_ff     <= ch_in;
      res_l_ff  <= res_l_in;
      res_r_ff  <= res_r_in;
      out_l_ff  <= out_l_in;
      out_r_ff  <= out_r_in;
   end
endmodule
